// ----- rtl/cpt_pkg.sv -----
// shared constants, types and helpers of the cursor pulse tint block
package cpt_pkg;

    // default geometry
    localparam int DEF_REACH_RADIUS = 20;
    localparam int DEF_COORD_BITS   = 12;

    // wave timing and full scale
    localparam int PERIOD_MS = 4000;
    localparam int HALF_MS   = 2000;
    localparam int FULL      = 255;

    // configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // floor(u / 125) == (u * RECIP_125) >> 34 for any u below 2**27
    localparam logic [27:0] RECIP_125       = 28'd137438954;
    localparam int          RECIP_125_SHIFT = 34;

    // floor(u / 2000) == (u * RECIP_HALF) >> 31 for any u below 2**19
    localparam logic [20:0] RECIP_HALF       = 21'd1073742;
    localparam int          RECIP_HALF_SHIFT = 31;

    // register indexes
    typedef enum logic [1:0] {
        REG_AMOUNT     = 2'd0,
        REG_TINT_RED   = 2'd1,
        REG_TINT_GREEN = 2'd2,
        REG_TINT_BLUE  = 2'd3
    } t_reg_idx;

    // configuration bundle handed to the datapath
    typedef struct packed {
        logic [7:0] amount;
        logic [7:0] tint_red;
        logic [7:0] tint_green;
        logic [7:0] tint_blue;
    } t_cfg;

    // one color
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // exact floor(x / 255) for x up to 255*255, adders only
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ----- rtl/cpt_regs.sv -----
// apb register file holding the tint amount and tint color
module cpt_regs import cpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);

    // write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_AMOUNT:     n_cfg.amount     = pwdata[7:0];
                REG_TINT_RED:   n_cfg.tint_red   = pwdata[7:0];
                REG_TINT_GREEN: n_cfg.tint_green = pwdata[7:0];
                REG_TINT_BLUE:  n_cfg.tint_blue  = pwdata[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_AMOUNT:     prdata = CFG_DATA_W'(r_cfg.amount);
            REG_TINT_RED:   prdata = CFG_DATA_W'(r_cfg.tint_red);
            REG_TINT_GREEN: prdata = CFG_DATA_W'(r_cfg.tint_green);
            REG_TINT_BLUE:  prdata = CFG_DATA_W'(r_cfg.tint_blue);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/cpt_near.sv -----
// four stage distance pipe: squared distance, reach test and nearness
module cpt_near import cpt_pkg::*; #(
    parameter int COORD_BITS   = DEF_COORD_BITS,
    parameter int REACH_RADIUS = DEF_REACH_RADIUS
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_cursor_col,
    input  logic [COORD_BITS-1:0] i_cursor_row,
    input  logic                  i_cursor_present,
    output logic                  o_hit,
    output logic [7:0]            o_near
);

    localparam int REACH = REACH_RADIUS * REACH_RADIUS;
    localparam int RB    = $clog2(REACH + 1);
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int D2_W  = 2 * COORD_BITS + 3;
    localparam int CMP_W = (D2_W > RB) ? D2_W : RB;
    // reciprocal of the reach, exact for numerators up to 255 * reach
    localparam int NS    = 2 * RB + 8;
    localparam int MN_W  = RB + 9;
    localparam int U_W   = RB + 8;
    localparam int P_W   = U_W + MN_W;
    localparam longint unsigned MN = ((64'd1 << NS) + REACH - 1) / REACH;
    localparam logic [MN_W-1:0] MN_V = MN_W'(MN);

    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_dy;
    logic                  r_pres1;
    logic [SQ_W-1:0]       r_dx2;
    logic [SQ_W-1:0]       r_dy2;
    logic                  r_pres2;
    logic                  r_hit3;
    logic [RB-1:0]         r_nd;
    logic                  r_hit4;
    logic [7:0]            r_near;

    logic [CMP_W-1:0]      w_d2;
    logic [CMP_W-1:0]      w_nd;
    logic [U_W-1:0]        w_u;
    logic [P_W-1:0]        w_pn;

    // stage 1: absolute differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= (i_col >= i_cursor_col) ? i_col - i_cursor_col : i_cursor_col - i_col;
            r_dy    <= (i_row >= i_cursor_row) ? i_row - i_cursor_row : i_cursor_row - i_row;
            r_pres1 <= i_cursor_present;
        end
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx2   <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_dy2   <= SQ_W'(r_dy) * SQ_W'(r_dy);
            r_pres2 <= r_pres1;
        end
    end

    // stage 3: rows count double, so dy squared weighs four times
    assign w_d2 = CMP_W'(r_dx2) + (CMP_W'(r_dy2) << 2);
    assign w_nd = CMP_W'(REACH) - w_d2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit3 <= r_pres2 && (w_d2 < CMP_W'(REACH));
            r_nd   <= w_nd[RB-1:0];
        end
    end

    // stage 4: nearness = (reach - d2) * 255 / reach
    assign w_u  = U_W'({r_nd, 8'd0}) - U_W'(r_nd);
    assign w_pn = P_W'(w_u) * P_W'(MN_V);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit4 <= r_hit3;
            r_near <= w_pn[NS+7:NS];
        end
    end

    assign o_hit  = r_hit4;
    assign o_near = r_near;

endmodule

// ----- rtl/cpt_wave.sv -----
// four stage triangle wave pipe: time modulo period and wave height
module cpt_wave import cpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_time_ms,
    output logic [7:0]  o_wave
);

    logic [6:0]  r_q7;
    logic [11:0] r_tlo;
    logic [11:0] r_phase;
    logic [18:0] r_wn;
    logic [7:0]  r_wave;

    logic [54:0] w_qp;
    logic [13:0] w_qm;
    logic [6:0]  w_rem;
    logic [10:0] w_w0;
    logic [39:0] w_pw;

    // stage 1: quotient of (time / 32) by 125, only its low bits matter
    assign w_qp = 55'(i_time_ms[31:5]) * 55'(RECIP_125);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q7  <= w_qp[RECIP_125_SHIFT+6:RECIP_125_SHIFT];
            r_tlo <= i_time_ms[11:0];
        end
    end

    // stage 2: phase = ((time / 32) mod 125) * 32 + time mod 32
    assign w_qm  = 14'(r_q7) * 14'd125;
    assign w_rem = r_tlo[11:5] - w_qm[6:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_phase <= {w_rem, r_tlo[4:0]};
        end
    end

    // stage 3: fold the falling half and scale by 255
    assign w_w0 = (r_phase < 12'(HALF_MS)) ? r_phase[10:0]
                                            : 11'(12'(PERIOD_MS) - r_phase);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wn <= 19'({w_w0, 8'd0}) - 19'(w_w0);
        end
    end

    // stage 4: divide by 2000
    assign w_pw = 40'(r_wn) * 40'(RECIP_HALF);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wave <= w_pw[RECIP_HALF_SHIFT+7:RECIP_HALF_SHIFT];
        end
    end

    assign o_wave = r_wave;

endmodule

// ----- rtl/cpt_mix.sv -----
// five stage strength and color mix pipe, last stage is the output register
module cpt_mix import cpt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_cfg       i_cfg,
    input  logic       i_hit,
    input  logic [7:0] i_near,
    input  logic [7:0] i_wave,
    input  logic       i_fg_valid,
    input  t_rgb       i_fg,
    output logic       o_out_valid,
    output t_rgb       o_rgb
);

    typedef struct packed {
        logic hit;
        logic fg_valid;
        t_rgb fg;
    } t_side;

    t_side       r_side5;
    t_side       r_side6;
    t_side       r_side7;
    t_side       r_side8;
    logic [15:0] r_p1;
    logic [7:0]  r_near5;
    logic [15:0] r_p2;
    logic [7:0]  r_a;
    logic [15:0] r_s_red;
    logic [15:0] r_s_green;
    logic [15:0] r_s_blue;
    logic        r_out_valid;
    t_rgb        r_rgb;

    logic [7:0]  w_q1;

    function automatic logic [15:0] mix_sum(input logic [7:0] f, input logic [7:0] t,
                                            input logic [7:0] a);
        logic [15:0] pf;
        logic [15:0] pt;
        pf = 16'(f) * 16'(8'(FULL) - a);
        pt = 16'(t) * 16'(a);
        return pf + pt;
    endfunction

    // stage 5: amount times wave
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1    <= 16'(i_cfg.amount) * 16'(i_wave);
            r_near5 <= i_near;
            r_side5 <= '{hit: i_hit, fg_valid: i_fg_valid, fg: i_fg};
        end
    end

    // stage 6: divide by 255, times nearness
    assign w_q1 = div255(r_p1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2    <= 16'(w_q1) * 16'(r_near5);
            r_side6 <= r_side5;
        end
    end

    // stage 7: final strength, never above 255
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= div255(r_p2);
            r_side7 <= r_side6;
        end
    end

    // stage 8: weighted sums per channel
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_red   <= mix_sum(r_side7.fg.red,   i_cfg.tint_red,   r_a);
            r_s_green <= mix_sum(r_side7.fg.green, i_cfg.tint_green, r_a);
            r_s_blue  <= mix_sum(r_side7.fg.blue,  i_cfg.tint_blue,  r_a);
            r_side8   <= r_side7;
        end
    end

    // stage 9: divide down or pass the cell color through
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_valid <= r_side8.hit || r_side8.fg_valid;
            if (r_side8.hit) begin
                r_rgb <= '{red:   div255(r_s_red),
                           green: div255(r_s_green),
                           blue:  div255(r_s_blue)};
            end else begin
                r_rgb <= r_side8.fg;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rgb       = r_rgb;

endmodule

// ----- rtl/cursor_pulse_tint.sv -----
// top level of the cursor pulse tint block
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid / tready         tdata: cell, cursor, time, color; tuser: fg_valid
//  m_axis    out  tvalid / tready         tdata: red, green, blue; tuser: out_valid
//  apb       in   psel, penable, pwrite   amount and tint color registers
//
//  one cell enters per clock unless m_axis stalls; results leave in the order of their requests
//  the depth is set by the distance and wave multipliers and the mix divides
//  a stall on m_axis freezes every stage at once through a common enable, so
//  s_axis_tready follows m_axis_tready whenever the output register is full
//  reset clears the stage valid bits and the configuration registers
module cursor_pulse_tint import cpt_pkg::*; #(
    parameter int COORD_BITS   = DEF_COORD_BITS,
    parameter int REACH_RADIUS = DEF_REACH_RADIUS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // col, row, cursor_col, cursor_row, cursor_present, time_ms,
    // fg_red, fg_green, fg_blue, zero padding
    input  logic [((4*COORD_BITS+57+7)/8)*8-1:0] s_axis_tdata,
    // fg_valid
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0]           m_axis_tdata,
    // out_valid
    output logic                  m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CB         = COORD_BITS;
    localparam int OFF_ROW    = CB;
    localparam int OFF_CCOL   = 2 * CB;
    localparam int OFF_CROW   = 3 * CB;
    localparam int OFF_PRES   = 4 * CB;
    localparam int OFF_TIME   = 4 * CB + 1;
    localparam int OFF_RED    = 4 * CB + 33;
    localparam int OFF_GREEN  = OFF_RED + 8;
    localparam int OFF_BLUE   = OFF_RED + 16;
    localparam int PIPE_DEPTH = 9;
    localparam int SIDE_DLY   = 4;

    t_cfg              w_cfg;
    logic              w_ce;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_rgb              w_fg_in;
    t_rgb              r_fg_dly [SIDE_DLY];
    logic [SIDE_DLY-1:0] r_fv_dly;
    logic              w_hit;
    logic [7:0]        w_near;
    logic [7:0]        w_wave;
    logic              w_out_valid;
    t_rgb              w_rgb;

    // common stage enable
    assign w_ce          = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_ce;
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];

    // valid bits travel with the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    // cell color waits for the distance and wave pipes
    assign w_fg_in = '{red:   s_axis_tdata[OFF_RED+:8],
                       green: s_axis_tdata[OFF_GREEN+:8],
                       blue:  s_axis_tdata[OFF_BLUE+:8]};

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_fg_dly[0] <= w_fg_in;
            for (int k = 1; k < SIDE_DLY; k++) begin
                r_fg_dly[k] <= r_fg_dly[k-1];
            end
            r_fv_dly <= {r_fv_dly[SIDE_DLY-2:0], s_axis_tuser};
        end
    end

    cpt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cpt_near #(
        .COORD_BITS   (COORD_BITS),
        .REACH_RADIUS (REACH_RADIUS)
    ) u_near (
        .i_clk            (i_clk),
        .i_en             (w_ce),
        .i_col            (s_axis_tdata[CB-1:0]),
        .i_row            (s_axis_tdata[OFF_ROW+:CB]),
        .i_cursor_col     (s_axis_tdata[OFF_CCOL+:CB]),
        .i_cursor_row     (s_axis_tdata[OFF_CROW+:CB]),
        .i_cursor_present (s_axis_tdata[OFF_PRES]),
        .o_hit            (w_hit),
        .o_near           (w_near)
    );

    cpt_wave u_wave (
        .i_clk     (i_clk),
        .i_en      (w_ce),
        .i_time_ms (s_axis_tdata[OFF_TIME+:32]),
        .o_wave    (w_wave)
    );

    cpt_mix u_mix (
        .i_clk       (i_clk),
        .i_en        (w_ce),
        .i_cfg       (w_cfg),
        .i_hit       (w_hit),
        .i_near      (w_near),
        .i_wave      (w_wave),
        .i_fg_valid  (r_fv_dly[SIDE_DLY-1]),
        .i_fg        (r_fg_dly[SIDE_DLY-1]),
        .o_out_valid (w_out_valid),
        .o_rgb       (w_rgb)
    );

    assign m_axis_tdata = {w_rgb.blue, w_rgb.green, w_rgb.red};
    assign m_axis_tuser = w_out_valid;

    // pipeline is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("stage valid bits not cleared by reset");

    // a stall freezes every stage valid bit
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> r_vld == $past(r_vld))
        else $error("stage valid bits moved during a stall");

    // an accepted request occupies the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_vld[0])
        else $error("accepted request lost at pipeline entry");

endmodule
